// ----- design/mtxc_pkg.sv -----
package mtxc_pkg;

  localparam int unsigned MT_N           = 624;
  localparam int unsigned MT_M           = 397;
  localparam int unsigned IDX_W          = $clog2(MT_N);
  localparam int unsigned WRAP_WORDS_DEF = 16777216;

  localparam logic [31:0] MT_MATRIX = 32'h9908b0df;
  localparam logic [31:0] MT_UPPER  = 32'h80000000;
  localparam logic [31:0] MT_LOWER  = 32'h7fffffff;
  localparam logic [31:0] SEED_MULT = 32'h6c078965;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc60000;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
    logic       last_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [31:0]      data;
  } ram_wr_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] key_seed;
    logic [31:0] s1;
    logic [31:0] s397;
  } seed_status_t;

  typedef struct packed {
    logic        avail;
    logic [31:0] word;
  } key_word_t;

  typedef struct packed {
    logic pop;
    logic restart;
  } stage_ctrl_t;

  function automatic logic [31:0] mix(input logic [31:0] u, input logic [31:0] v);
    logic [31:0] y;
    y = (u & MT_UPPER) | (v & MT_LOWER);
    return (y >> 1) ^ (v[0] ? MT_MATRIX : 32'h0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] r;
    r = x ^ (x >> 11);
    r = r ^ ((r << 7) & TEMPER_B);
    r = r ^ ((r << 15) & TEMPER_C);
    r = r ^ (r >> 18);
    return r;
  endfunction

  function automatic logic [31:0] seed_next(input logic [31:0] p, input logic [IDX_W-1:0] i);
    logic [31:0] q;
    q = p ^ (p >> 30);
    return SEED_MULT * q + 32'(i);
  endfunction

endpackage

// ----- design/mtxc_stream_if.sv -----
interface mtxc_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/mtxc_ram.sv -----
module mtxc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/mtxc_seeder.sv -----
module mtxc_seeder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data,
  output mtxc_pkg::seed_status_t st,
  output mtxc_pkg::ram_wr_t      sd_wr
);
  import mtxc_pkg::*;

  logic [31:0]      key_seed;
  logic             busy;
  logic             done;
  logic [IDX_W-1:0] idx;
  logic [31:0]      p;
  logic [31:0]      s1;
  logic [31:0]      s397;
  logic [31:0]      val;

  assign val = (idx == '0) ? key_seed : seed_next(p, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seed <= '0;
      busy     <= 1'b1;
      done     <= 1'b0;
      idx      <= '0;
    end else if (cfg_wr_en) begin
      key_seed <= cfg_wr_data;
      busy     <= 1'b1;
      done     <= 1'b0;
      idx      <= '0;
    end else begin
      done <= busy && (idx == IDX_W'(MT_N - 1));
      if (busy) begin
        idx <= idx + 1'b1;
        if (idx == IDX_W'(MT_N - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      p <= val;
      if (idx == IDX_W'(1)) begin
        s1 <= val;
      end
      if (idx == IDX_W'(MT_M)) begin
        s397 <= val;
      end
    end
  end

  assign sd_wr.en   = busy;
  assign sd_wr.addr = idx;
  assign sd_wr.data = val;

  assign st.busy     = busy;
  assign st.done     = done;
  assign st.key_seed = key_seed;
  assign st.s1       = s1;
  assign st.s397     = s397;

endmodule

// ----- design/mtxc_gen.sv -----
module mtxc_gen #(
  parameter int unsigned WRAP_WORDS = mtxc_pkg::WRAP_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mtxc_pkg::seed_status_t       seed,
  input  mtxc_pkg::stage_ctrl_t        ctrl,
  output mtxc_pkg::key_word_t          kw,
  output mtxc_pkg::ram_wr_t            wk_wr,
  output logic [mtxc_pkg::IDX_W-1:0]   rd_addr1,
  output logic [mtxc_pkg::IDX_W-1:0]   rd_addr2,
  input  logic [31:0]                  wk_rd1,
  input  logic [31:0]                  wk_rd2,
  input  logic [31:0]                  sd_rd1,
  input  logic [31:0]                  sd_rd2
);
  import mtxc_pkg::*;

  localparam int unsigned WCW = $clog2(WRAP_WORDS);

  logic             run;
  logic             fresh;
  logic             first_pass;
  logic [IDX_W-1:0] j;
  logic [WCW-1:0]   wc;
  logic             c_valid;
  logic             c_fresh;
  logic             c_use1;
  logic             c_use2;
  logic [IDX_W-1:0] c_j;
  logic [31:0]      xhold;
  logic [31:0]      e0;
  logic [31:0]      e1;
  logic [1:0]       count;

  logic             restart;
  logic             issue;
  logic [IDX_W:0]   far_sum;
  logic [31:0]      x624;
  logic [31:0]      w0;
  logic [31:0]      v1;
  logic [31:0]      v2;
  logic [31:0]      xj;
  logic [31:0]      nx;
  logic [31:0]      nx_t;
  logic             push;

  assign restart = ctrl.restart || seed.done;
  assign issue   = run && ((count + 2'(c_valid)) < 2'd2);

  assign rd_addr1 = (j == IDX_W'(MT_N - 1)) ? '0 : j + 1'b1;
  assign far_sum  = {1'b0, j} + (IDX_W + 1)'(MT_M);
  assign rd_addr2 = (far_sum >= (IDX_W + 1)'(MT_N)) ?
                    IDX_W'(far_sum - (IDX_W + 1)'(MT_N)) : IDX_W'(far_sum);

  assign x624 = seed.s397 ^ mix(seed.key_seed, seed.s1);
  assign w0   = temper(x624);

  assign v1   = c_use1 ? wk_rd1 : sd_rd1;
  assign v2   = c_use2 ? wk_rd2 : sd_rd2;
  assign xj   = c_fresh ? ((c_j == '0) ? seed.key_seed : seed.s1) : xhold;
  assign nx   = v2 ^ mix(xj, v1);
  assign nx_t = temper(nx);
  assign push = c_valid && !restart;

  always_comb begin
    if (restart) begin
      wk_wr.en   = 1'b1;
      wk_wr.addr = '0;
      wk_wr.data = x624;
    end else begin
      wk_wr.en   = c_valid;
      wk_wr.addr = c_j;
      wk_wr.data = nx;
    end
  end

  // issue side
  always_ff @(posedge clk) begin
    if (rst || seed.busy) begin
      run     <= 1'b0;
      c_valid <= 1'b0;
    end else if (restart) begin
      run        <= 1'b1;
      fresh      <= 1'b1;
      first_pass <= 1'b1;
      j          <= IDX_W'(1);
      wc         <= WCW'(1);
      c_valid    <= 1'b0;
    end else begin
      c_valid <= issue;
      if (issue) begin
        c_fresh <= fresh;
        c_j     <= j;
        c_use1  <= !first_pass || (rd_addr1 < j);
        c_use2  <= !first_pass || (rd_addr2 < j);
        if (wc == WCW'(WRAP_WORDS - 1)) begin
          wc         <= '0;
          j          <= '0;
          first_pass <= 1'b1;
          fresh      <= 1'b1;
        end else begin
          wc    <= wc + 1'b1;
          fresh <= 1'b0;
          if (j == IDX_W'(MT_N - 1)) begin
            j          <= '0;
            first_pass <= 1'b0;
          end else begin
            j <= j + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid) begin
      xhold <= v1;
    end
  end

  // two-entry word queue
  always_ff @(posedge clk) begin
    if (rst || seed.busy) begin
      count <= '0;
    end else if (restart) begin
      count <= 2'd1;
    end else begin
      case ({ctrl.pop, push})
        2'b11:   count <= count;
        2'b10:   count <= count - 1'b1;
        2'b01:   count <= count + 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      e0 <= w0;
    end else begin
      case ({ctrl.pop, push})
        2'b11: begin
          if (count == 2'd1) begin
            e0 <= nx_t;
          end else begin
            e0 <= e1;
            e1 <= nx_t;
          end
        end
        2'b10: begin
          e0 <= e1;
        end
        2'b01: begin
          if (count == 2'd0) begin
            e0 <= nx_t;
          end else begin
            e1 <= nx_t;
          end
        end
        default: begin
          e0 <= e0;
        end
      endcase
    end
  end

  assign kw.avail = (count != 2'd0);
  assign kw.word  = e0;

endmodule

// ----- design/mtxc_byte_stage.sv -----
module mtxc_byte_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seed_busy,
  input  mtxc_pkg::key_word_t   kw,
  output mtxc_pkg::stage_ctrl_t ctrl,
  mtxc_stream_if.sink           item,
  mtxc_stream_if.source         result
);
  import mtxc_pkg::*;

  logic [1:0]  lane;
  logic [31:0] cur_word;
  logic [7:0]  prev_plain;
  logic        out_valid;
  result_t     out_data;

  logic        can_take;
  logic        accept;
  logic [31:0] word;
  logic [7:0]  ks;
  logic [7:0]  res;

  assign can_take   = !out_valid || result.ready;
  assign item.ready = !seed_busy && can_take && ((lane != 2'd0) || kw.avail);
  assign accept     = item.valid && item.ready;

  assign word = (lane == 2'd0) ? kw.word : cur_word;
  assign ks   = word[{lane, 3'b000} +: 8];
  assign res  = item.data.in_byte ^ ks ^ prev_plain;

  assign ctrl.pop     = accept && (lane == 2'd0);
  assign ctrl.restart = accept && item.data.last_of_message;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane       <= '0;
      prev_plain <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (can_take) begin
        out_valid <= accept;
      end
      if (seed_busy) begin
        lane       <= '0;
        prev_plain <= '0;
      end else if (accept) begin
        if (item.data.last_of_message) begin
          lane       <= '0;
          prev_plain <= '0;
        end else begin
          lane       <= lane + 1'b1;
          prev_plain <= item.data.kind ? res : item.data.in_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.out_byte <= res;
      out_data.last_out <= item.data.last_of_message;
    end
    if (ctrl.pop) begin
      cur_word <= kw.word;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// ----- design/mt19937_chained_xor_cipher.sv -----
// output: a registered result is presented in the cycle after its input transfer
// throughput: one byte per cycle unless results stall, also across messages; the
//   generator computes one tempered word per cycle into its two-entry queue while
//   it has room, from working and seeded tables; a word serves up to four bytes
// reset and seed write: the seeded table is rebuilt at one entry per cycle,
//   so no byte is taken while it is rebuilt; the seed register resets to zero
module mt19937_chained_xor_cipher #(
  parameter int unsigned WRAP_WORDS = mtxc_pkg::WRAP_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  mtxc_stream_if.sink   item,
  mtxc_stream_if.source result
);
  import mtxc_pkg::*;

  seed_status_t     seed_st;
  ram_wr_t          sd_wr;
  ram_wr_t          wk_wr;
  logic [IDX_W-1:0] rd_addr1;
  logic [IDX_W-1:0] rd_addr2;
  logic [31:0]      sd_rd1;
  logic [31:0]      sd_rd2;
  logic [31:0]      wk_rd1;
  logic [31:0]      wk_rd2;
  key_word_t        kw;
  stage_ctrl_t      sctrl;

  mtxc_seeder u_seeder (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .st          (seed_st),
    .sd_wr       (sd_wr)
  );

  mtxc_ram #(
    .WIDTH (32),
    .DEPTH (MT_N)
  ) u_seeded_ram (
    .clk     (clk),
    .we      (sd_wr.en),
    .waddr   (sd_wr.addr),
    .wdata   (sd_wr.data),
    .raddr_a (rd_addr1),
    .raddr_b (rd_addr2),
    .rdata_a (sd_rd1),
    .rdata_b (sd_rd2)
  );

  mtxc_ram #(
    .WIDTH (32),
    .DEPTH (MT_N)
  ) u_work_ram (
    .clk     (clk),
    .we      (wk_wr.en),
    .waddr   (wk_wr.addr),
    .wdata   (wk_wr.data),
    .raddr_a (rd_addr1),
    .raddr_b (rd_addr2),
    .rdata_a (wk_rd1),
    .rdata_b (wk_rd2)
  );

  mtxc_gen #(
    .WRAP_WORDS (WRAP_WORDS)
  ) u_gen (
    .clk      (clk),
    .rst      (rst),
    .seed     (seed_st),
    .ctrl     (sctrl),
    .kw       (kw),
    .wk_wr    (wk_wr),
    .rd_addr1 (rd_addr1),
    .rd_addr2 (rd_addr2),
    .wk_rd1   (wk_rd1),
    .wk_rd2   (wk_rd2),
    .sd_rd1   (sd_rd1),
    .sd_rd2   (sd_rd2)
  );

  mtxc_byte_stage u_stage (
    .clk       (clk),
    .rst       (rst),
    .seed_busy (seed_st.busy),
    .kw        (kw),
    .ctrl      (sctrl),
    .item      (item),
    .result    (result)
  );

  // first word of the next message is ready right after a last-byte transfer
  assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.data.last_of_message) |=> kw.avail)
    else $error("word queue not reloaded after message end");

  // a held result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !(item.valid && item.ready))
    else $error("input transfer while result stalled");

  // every input transfer yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> result.valid)
    else $error("result missing after input transfer");

  // no byte is taken while the seeded table is rebuilt
  assert property (@(posedge clk) disable iff (rst)
    seed_st.busy |-> !(item.valid && item.ready))
    else $error("input transfer during seeding");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mtxc_pkg::item_t;
  import mtxc_pkg::result_t;

  localparam int unsigned TABLE_LEN   = 624;
  localparam int unsigned TWIST_OFS   = 397;
  localparam int unsigned WRAP_AT     = 1024;
  localparam logic [31:0] TWIST_XOR   = 32'h9908b0df;
  localparam logic [31:0] INIT_MULT   = 32'h6c078965;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc60000;
  localparam logic [31:0] STD_SEED    = 32'd5489;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic ENCODE = 1'b0;
  localparam logic DECODE = 1'b1;

  typedef struct packed {
    logic       reseed;
    logic       kind;
    logic [7:0] in_byte;
    logic       last;
    logic       typed;
    logic [7:0] want;
  } directed_row_t;

  localparam int N_DIRECTED = 22;

  // reset seed first, then the standard seed whose first words are well known
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, ENCODE, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, ENCODE, 8'hff, 1'b0, 1'b0, 8'h00},
    '{1'b0, DECODE, 8'ha5, 1'b0, 1'b0, 8'h00},
    '{1'b0, DECODE, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, ENCODE, 8'h80, 1'b1, 1'b0, 8'h00},
    '{1'b0, DECODE, 8'h01, 1'b0, 1'b0, 8'h00},
    '{1'b1, ENCODE, 8'h00, 1'b0, 1'b1, 8'h5c},
    '{1'b0, ENCODE, 8'h00, 1'b0, 1'b1, 8'hbb},
    '{1'b0, ENCODE, 8'h00, 1'b0, 1'b1, 8'h91},
    '{1'b0, ENCODE, 8'h00, 1'b1, 1'b1, 8'hd0},
    '{1'b0, ENCODE, 8'hff, 1'b0, 1'b1, 8'ha3},
    '{1'b0, ENCODE, 8'h00, 1'b0, 1'b1, 8'h44},
    '{1'b0, ENCODE, 8'h00, 1'b0, 1'b1, 8'h91},
    '{1'b0, ENCODE, 8'h00, 1'b0, 1'b1, 8'hd0},
    '{1'b0, ENCODE, 8'h00, 1'b0, 1'b1, 8'hf6},
    '{1'b0, ENCODE, 8'h00, 1'b1, 1'b1, 8'h9e},
    '{1'b0, DECODE, 8'h5c, 1'b0, 1'b1, 8'h00},
    '{1'b0, DECODE, 8'hbb, 1'b0, 1'b1, 8'h00},
    '{1'b0, DECODE, 8'h6e, 1'b1, 1'b1, 8'hff},
    '{1'b0, DECODE, 8'hff, 1'b0, 1'b1, 8'ha3},
    '{1'b0, ENCODE, 8'h7f, 1'b1, 1'b1, 8'h67},
    '{1'b0, ENCODE, 8'h55, 1'b1, 1'b1, 8'h09}
  };

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  mtxc_stream_if #(.data_t(item_t))   item_ch ();
  mtxc_stream_if #(.data_t(result_t)) result_ch ();

  mt19937_chained_xor_cipher #(
    .WRAP_WORDS(WRAP_AT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item(item_ch),
    .result(result_ch)
  );

  logic [31:0] seed_tab [TABLE_LEN];
  logic [31:0] work_tab [TABLE_LEN];
  int unsigned tab_pos;
  int unsigned words_drawn;
  logic [1:0]  lane;
  logic [31:0] key_word;
  logic [7:0]  prev_plain;

  result_t     expected_bytes [$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  int          src_idle_pct = 25;
  int          snk_idle_pct = 74;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void load_seed(input logic [31:0] seed);
    logic [31:0] p;
    int unsigned i;
    seed_tab[0] = seed;
    for (i = 1; i < TABLE_LEN; i++) begin
      p = seed_tab[i-1];
      seed_tab[i] = INIT_MULT * (p ^ (p >> 30)) + i;
    end
  endfunction

  function automatic void rewind_keystream();
    work_tab = seed_tab;
    tab_pos = TABLE_LEN;
    words_drawn = 0;
  endfunction

  function automatic void open_message();
    rewind_keystream();
    lane = 2'd0;
    key_word = 32'h0;
    prev_plain = 8'h00;
  endfunction

  function automatic void twist();
    logic [31:0] y;
    int unsigned k;
    int unsigned nx;
    for (k = 0; k < TABLE_LEN; k++) begin
      nx = (k + 1) % TABLE_LEN;
      y = {work_tab[k][31], work_tab[nx][30:0]};
      work_tab[k] = work_tab[(k + TWIST_OFS) % TABLE_LEN] ^ (y >> 1)
                    ^ (work_tab[nx][0] ? TWIST_XOR : 32'h0);
    end
  endfunction

  function automatic logic [31:0] draw_word();
    logic [31:0] r;
    if (tab_pos >= TABLE_LEN) begin
      twist();
      tab_pos = 0;
    end
    r = work_tab[tab_pos];
    tab_pos++;
    r = r ^ (r >> 11);
    r = r ^ ((r << 7) & TEMPER_B);
    r = r ^ ((r << 15) & TEMPER_C);
    r = r ^ (r >> 18);
    words_drawn++;
    if (words_drawn >= WRAP_AT) rewind_keystream();
    return r;
  endfunction

  function automatic result_t cipher_byte(input item_t it);
    result_t    res;
    logic [7:0] ks;
    if (lane == 2'd0) key_word = draw_word();
    ks = key_word[8*lane +: 8];
    lane = lane + 2'd1;
    res.out_byte = it.in_byte ^ ks ^ prev_plain;
    res.last_out = it.last_of_message;
    prev_plain = (it.kind == DECODE) ? res.out_byte : it.in_byte;
    if (it.last_of_message) open_message();
    return res;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic push_item(input logic kind, input logic [7:0] in_byte, input logic last,
                           input logic typed, input logic [7:0] want);
    item_t   it;
    result_t res;
    it.kind = kind;
    it.in_byte = in_byte;
    it.last_of_message = last;
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    do @(posedge clk); while (!item_ch.ready);
    res = cipher_byte(it);
    if (typed) res.out_byte = want;
    expected_bytes.insert(expected_bytes.size(), res);
    @(negedge clk);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= seed;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    load_seed(seed);
    open_message();
  endtask

  task automatic send_message(input int len, input int unsigned style, input logic closes);
    int   i;
    logic kind;
    for (i = 0; i < len; i++) begin
      kind = (style < 4) ? ENCODE : (style < 7) ? DECODE : 1'($urandom);
      push_item(kind, pick_byte(), closes && (i == len - 1), 1'b0, 8'h00);
    end
  endtask

  task automatic send_messages(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: len = $urandom_range(300, 81);
        1, 2, 3, 4, 5: len = $urandom_range(80, 13);
        default: len = $urandom_range(12, 1);
      endcase
      send_message(len, $urandom_range(9), $urandom_range(9) != 0);
      sent += len;
      if ($urandom_range(9) == 0) settle();
    end
    // leave the stream mid-message so the next seed write lands inside one
    send_message($urandom_range(4, 1), 9, 1'b0);
  endtask

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected transfer, out_byte", result_ch.data.out_byte, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (result_ch.data.out_byte !== want.out_byte)
          report_mismatch("out_byte", result_ch.data.out_byte, want.out_byte);
        if (result_ch.data.last_out !== want.last_out)
          report_mismatch("last_out", {7'b0, result_ch.data.last_out}, {7'b0, want.last_out});
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[mt19937_chained_xor_cipher] ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 32'h0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    load_seed(32'h0);
    open_message();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].reseed) write_seed(STD_SEED);
      push_item(directed_rows[r].kind, directed_rows[r].in_byte, directed_rows[r].last,
                directed_rows[r].typed, directed_rows[r].want);
    end
    send_messages(130);

    write_seed(32'hffffffff);
    src_idle_pct = 74;
    snk_idle_pct = 25;
    send_messages(130);

    write_seed($urandom);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_messages(130);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("[mt19937_chained_xor_cipher] OK");
    end else begin
      $display("[mt19937_chained_xor_cipher] ERROR");
    end
    $finish;
  end

endmodule
